// ===== sv/rvsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rvsr_pkg
// shared types, constants and helpers of the remote velocity slew ramp
// ----------------------------------------------------------------------------
package rvsr_pkg;

  localparam int VEL_W     = 20;
  localparam int ACC_W     = 10;
  localparam int DT_W      = 8;
  localparam int TMO_W     = 16;
  localparam int DB_W      = 8;
  localparam int SEQ_W     = 32;
  localparam int TIME_W    = 32;
  localparam int STEP_W    = ACC_W + DT_W;
  // wide enough for cur +/- step without overflow
  localparam int SLEW_W    = ((VEL_W > STEP_W + 1) ? VEL_W : STEP_W + 1) + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [ACC_W-1:0]  FWD_ACCEL_RST  = ACC_W'(20);
  localparam logic [ACC_W-1:0]  TURN_ACCEL_RST = ACC_W'(24);
  localparam logic [ACC_W-1:0]  STOP_ACCEL_RST = ACC_W'(30);
  localparam logic [TMO_W-1:0]  TIMEOUT_RST    = TMO_W'(200);
  localparam logic [DB_W-1:0]   DEADBAND_RST   = DB_W'(1);
  localparam logic [DT_W-1:0]   MAX_DT_RST     = DT_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FWD_ACCEL  = 3'd0,
    CFG_TURN_ACCEL = 3'd1,
    CFG_STOP_ACCEL = 3'd2,
    CFG_TIMEOUT    = 3'd3,
    CFG_DEADBAND   = 3'd4,
    CFG_MAX_DT     = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ACT_CMD  = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef struct packed {
    logic [ACC_W-1:0] fwd_accel;
    logic [ACC_W-1:0] turn_accel;
    logic [ACC_W-1:0] stop_accel;
    logic [TMO_W-1:0] timeout_ms;
    logic [DB_W-1:0]  deadband;
    logic [DT_W-1:0]  max_dt_ms;
  } cfg_t;

  typedef struct packed {
    action_e                  action;
    logic [TIME_W-1:0]        now_ms;
    logic [SEQ_W-1:0]         cmd_seq;
    logic [SEQ_W-1:0]         remote_seq;
    logic                     preset;
    logic                     has_fwd;
    logic                     has_turn;
    logic signed [VEL_W-1:0]  fwd_value;
    logic signed [VEL_W-1:0]  turn_value;
    logic                     stop;
    logic                     disable_req;
  } item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]  ramped_fwd;
    logic signed [VEL_W-1:0]  ramped_turn;
    logic                     target_active;
    logic                     cmd_taken;
  } res_t;

  // magnitude of a velocity, one bit wider so the most negative value fits
  function automatic logic [VEL_W:0] vel_mag(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W:0] ext;
    ext = (VEL_W+1)'(v);
    return ext[VEL_W] ? (VEL_W+1)'(-ext) : (VEL_W+1)'(ext);
  endfunction

endpackage

// ===== sv/rvsr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rvsr_cfg_regs
// configuration register file, written one register per transfer
// ----------------------------------------------------------------------------
module rvsr_cfg_regs import rvsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_accel  <= FWD_ACCEL_RST;
      cfg_q.turn_accel <= TURN_ACCEL_RST;
      cfg_q.stop_accel <= STOP_ACCEL_RST;
      cfg_q.timeout_ms <= TIMEOUT_RST;
      cfg_q.deadband   <= DEADBAND_RST;
      cfg_q.max_dt_ms  <= MAX_DT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FWD_ACCEL:  cfg_q.fwd_accel  <= cfg_data_i[ACC_W-1:0];
        CFG_TURN_ACCEL: cfg_q.turn_accel <= cfg_data_i[ACC_W-1:0];
        CFG_STOP_ACCEL: cfg_q.stop_accel <= cfg_data_i[ACC_W-1:0];
        CFG_TIMEOUT:    cfg_q.timeout_ms <= cfg_data_i[TMO_W-1:0];
        CFG_DEADBAND:   cfg_q.deadband   <= cfg_data_i[DB_W-1:0];
        CFG_MAX_DT:     cfg_q.max_dt_ms  <= cfg_data_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/rvsr_slew.sv =====
// ----------------------------------------------------------------------------
// rvsr_slew
// one channel of the ramp: step select, step = accel * dt, bounded move
// ----------------------------------------------------------------------------
module rvsr_slew import rvsr_pkg::*; (
  input  logic signed [VEL_W-1:0] cur_i,
  input  logic signed [VEL_W-1:0] tgt_i,
  input  logic [ACC_W-1:0]        accel_i,
  input  logic [ACC_W-1:0]        stop_accel_i,
  input  logic [DB_W-1:0]         deadband_i,
  input  logic [DT_W-1:0]         dt_i,
  output logic signed [VEL_W-1:0] nxt_o
);

  logic [ACC_W-1:0]         acc_sel;
  logic [STEP_W-1:0]        step;
  logic signed [SLEW_W-1:0] cur_x;
  logic signed [SLEW_W-1:0] tgt_x;
  logic signed [SLEW_W-1:0] step_x;
  logic signed [SLEW_W-1:0] up;
  logic signed [SLEW_W-1:0] dn;

  // target inside deadband ramps at the stop rate
  assign acc_sel = (vel_mag(tgt_i) < (VEL_W+1)'(deadband_i)) ? stop_accel_i : accel_i;
  assign step    = STEP_W'(acc_sel) * STEP_W'(dt_i);

  assign cur_x  = SLEW_W'(cur_i);
  assign tgt_x  = SLEW_W'(tgt_i);
  assign step_x = signed'(SLEW_W'(step));
  assign up     = cur_x + step_x;
  assign dn     = cur_x - step_x;

  always_comb begin
    if (tgt_x > up) begin
      nxt_o = up[VEL_W-1:0];
    end else if (tgt_x < dn) begin
      nxt_o = dn[VEL_W-1:0];
    end else begin
      nxt_o = tgt_i;
    end
  end

endmodule

// ===== sv/rvsr_core.sv =====
// ----------------------------------------------------------------------------
// rvsr_core
// command and tick handling with the ramp and watchdog state
// ----------------------------------------------------------------------------
module rvsr_core import rvsr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [SEQ_W-1:0]        last_cmd_seq_q, last_cmd_seq_d;
  logic [SEQ_W-1:0]        last_remote_seq_q, last_remote_seq_d;
  logic [TIME_W-1:0]       last_remote_time_q, last_remote_time_d;
  logic [TIME_W-1:0]       last_ramp_time_q, last_ramp_time_d;
  logic signed [VEL_W-1:0] target_fwd_q, target_fwd_d;
  logic signed [VEL_W-1:0] target_turn_q, target_turn_d;
  logic signed [VEL_W-1:0] out_fwd_q, out_fwd_d;
  logic signed [VEL_W-1:0] out_turn_q, out_turn_d;
  logic                    active_flag_q, active_flag_d;

  logic                    is_tick;
  logic                    taken;
  logic                    has_any;
  logic                    stale;
  logic                    expire;
  logic                    dt_clamp;
  logic [TIME_W-1:0]       ramp_elapsed;
  logic [DT_W-1:0]         dt;
  logic signed [VEL_W-1:0] tick_tgt_fwd;
  logic signed [VEL_W-1:0] tick_tgt_turn;
  logic signed [VEL_W-1:0] slew_fwd;
  logic signed [VEL_W-1:0] slew_turn;
  logic signed [VEL_W-1:0] new_tgt_fwd;
  logic signed [VEL_W-1:0] new_tgt_turn;

  assign is_tick = (item_i.action == ACT_TICK);
  assign taken   = !is_tick && (item_i.cmd_seq != '0) && (item_i.cmd_seq != last_cmd_seq_q);
  assign has_any = item_i.has_fwd || item_i.has_turn;
  assign stale   = (item_i.remote_seq != '0) && (item_i.remote_seq < last_remote_seq_q);

  // tick side
  assign expire = active_flag_q &&
                  ((item_i.now_ms - last_remote_time_q) > TIME_W'(cfg_i.timeout_ms));
  assign tick_tgt_fwd  = expire ? '0 : target_fwd_q;
  assign tick_tgt_turn = expire ? '0 : target_turn_q;

  assign ramp_elapsed = item_i.now_ms - last_ramp_time_q;
  assign dt_clamp     = ramp_elapsed > TIME_W'(cfg_i.max_dt_ms);
  always_comb begin
    if (last_ramp_time_q == '0) begin
      dt = '0;
    end else if (dt_clamp) begin
      dt = cfg_i.max_dt_ms;
    end else begin
      dt = ramp_elapsed[DT_W-1:0];
    end
  end

  rvsr_slew u_slew_fwd (
    .cur_i        (out_fwd_q),
    .tgt_i        (tick_tgt_fwd),
    .accel_i      (cfg_i.fwd_accel),
    .stop_accel_i (cfg_i.stop_accel),
    .deadband_i   (cfg_i.deadband),
    .dt_i         (dt),
    .nxt_o        (slew_fwd)
  );

  rvsr_slew u_slew_turn (
    .cur_i        (out_turn_q),
    .tgt_i        (tick_tgt_turn),
    .accel_i      (cfg_i.turn_accel),
    .stop_accel_i (cfg_i.stop_accel),
    .deadband_i   (cfg_i.deadband),
    .dt_i         (dt),
    .nxt_o        (slew_turn)
  );

  // command side
  assign new_tgt_fwd  = item_i.has_fwd  ? item_i.fwd_value  : target_fwd_q;
  assign new_tgt_turn = item_i.has_turn ? item_i.turn_value : target_turn_q;

  always_comb begin
    last_cmd_seq_d     = last_cmd_seq_q;
    last_remote_seq_d  = last_remote_seq_q;
    last_remote_time_d = last_remote_time_q;
    last_ramp_time_d   = last_ramp_time_q;
    target_fwd_d       = target_fwd_q;
    target_turn_d      = target_turn_q;
    out_fwd_d          = out_fwd_q;
    out_turn_d         = out_turn_q;
    active_flag_d      = active_flag_q;
    if (is_tick) begin
      target_fwd_d     = tick_tgt_fwd;
      target_turn_d    = tick_tgt_turn;
      active_flag_d    = active_flag_q && !expire;
      last_ramp_time_d = item_i.now_ms;
      out_fwd_d        = slew_fwd;
      out_turn_d       = slew_turn;
    end else if (taken) begin
      last_cmd_seq_d = item_i.cmd_seq;
      if (item_i.preset) begin
        out_fwd_d  = item_i.fwd_value;
        out_turn_d = item_i.turn_value;
      end
      if (has_any && !stale) begin
        if (item_i.remote_seq != '0) begin
          last_remote_seq_d = item_i.remote_seq;
        end
        target_fwd_d       = new_tgt_fwd;
        target_turn_d      = new_tgt_turn;
        active_flag_d      = (vel_mag(new_tgt_fwd)  > (VEL_W+1)'(cfg_i.deadband)) ||
                             (vel_mag(new_tgt_turn) > (VEL_W+1)'(cfg_i.deadband));
        last_remote_time_d = item_i.now_ms;
      end
      // stale remote part also skips stop and disable
      if ((item_i.stop || item_i.disable_req) && !(has_any && stale)) begin
        target_fwd_d  = '0;
        target_turn_d = '0;
        active_flag_d = 1'b0;
        out_fwd_d     = '0;
        out_turn_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_seq_q     <= '0;
      last_remote_seq_q  <= '0;
      last_remote_time_q <= '0;
      last_ramp_time_q   <= '0;
      target_fwd_q       <= '0;
      target_turn_q      <= '0;
      out_fwd_q          <= '0;
      out_turn_q         <= '0;
      active_flag_q      <= 1'b0;
    end else if (item_valid_i) begin
      last_cmd_seq_q     <= last_cmd_seq_d;
      last_remote_seq_q  <= last_remote_seq_d;
      last_remote_time_q <= last_remote_time_d;
      last_ramp_time_q   <= last_ramp_time_d;
      target_fwd_q       <= target_fwd_d;
      target_turn_q      <= target_turn_d;
      out_fwd_q          <= out_fwd_d;
      out_turn_q         <= out_turn_d;
      active_flag_q      <= active_flag_d;
    end
  end

  assign res_o.ramped_fwd    = out_fwd_d;
  assign res_o.ramped_turn   = out_turn_d;
  assign res_o.target_active = active_flag_d;
  assign res_o.cmd_taken     = taken;

  // an active target is never zero on both channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_flag_q |-> (target_fwd_q != '0 || target_turn_q != '0))
    else $error("active flag set with both targets zero");

  // a tick always records its time as the ramp reference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && is_tick |=> last_ramp_time_q == $past(item_i.now_ms))
    else $error("ramp time not updated by tick");

  // a dropped command leaves the ramp and targets untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && !is_tick && !taken |=>
      $stable(out_fwd_q) && $stable(out_turn_q) && $stable(target_fwd_q) &&
      $stable(target_turn_q) && $stable(active_flag_q))
    else $error("dropped command changed state");

endmodule

// ===== sv/remote_velocity_slew_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// remote_velocity_slew_ramp_unit
// two channel remote velocity slew limiter with command watchdog
// ----------------------------------------------------------------------------
// path: an input transfer loads the input register, then the item moves on into
//   the result register, where its result is offered to the receiver
// throughput: one item per cycle while the receiver does not stall, set by the
//   single pass through the core logic between the input and result registers
// reset: rst_ni clears all ramp state, targets and sequences to zero, loads
//   the register defaults and empties both pipeline registers
// ----------------------------------------------------------------------------
module remote_velocity_slew_ramp_unit import rvsr_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [TIME_W-1:0]             now_ms_i,
  input  logic [SEQ_W-1:0]              cmd_seq_i,
  input  logic [SEQ_W-1:0]              remote_seq_i,
  input  logic                          preset_i,
  input  logic                          has_fwd_i,
  input  logic                          has_turn_i,
  input  logic signed [VEL_W-1:0]       fwd_value_i,
  input  logic signed [VEL_W-1:0]       turn_value_i,
  input  logic                          stop_i,
  input  logic                          disable_req_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VEL_W-1:0]       ramped_fwd_o,
  output logic signed [VEL_W-1:0]       ramped_turn_o,
  output logic                          target_active_o,
  output logic                          cmd_taken_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DAT_W-1:0]          cfg_data_i
);

  cfg_t  cfg;
  item_t in_q;
  logic  in_valid_q, in_valid_d;
  res_t  res_q;
  res_t  res_c;
  logic  out_valid_q, out_valid_d;
  logic  in_xfer;
  logic  advance;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  rvsr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // item moves into the result register when that register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register, payload only, loaded on an input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.action      <= action_e'(action_i);
      in_q.now_ms      <= now_ms_i;
      in_q.cmd_seq     <= cmd_seq_i;
      in_q.remote_seq  <= remote_seq_i;
      in_q.preset      <= preset_i;
      in_q.has_fwd     <= has_fwd_i;
      in_q.has_turn    <= has_turn_i;
      in_q.fwd_value   <= fwd_value_i;
      in_q.turn_value  <= turn_value_i;
      in_q.stop        <= stop_i;
      in_q.disable_req <= disable_req_i;
    end
  end

  // core state commits on the same edge the result is captured
  rvsr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (advance),
    .item_i       (in_q),
    .cfg_i        (cfg),
    .res_o        (res_c)
  );

  // result register, holds while the result side stalls
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_c;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ramped_fwd_o    = res_q.ramped_fwd;
  assign ramped_turn_o   = res_q.ramped_turn;
  assign target_active_o = res_q.target_active;
  assign cmd_taken_o     = res_q.cmd_taken;

  // a held input item is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("stalled input item lost");

  // a stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_q))
    else $error("stalled result changed");

  // an empty input register never stalls the sender
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("stall raised with empty input register");

endmodule

// ===== tb/sv/tb_remote_velocity_slew_ramp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_remote_velocity_slew_ramp_unit
// self-checking bench for the remote velocity slew ramp: a short directed run
// over the sequence, preset, stop, timeout and time-wrap cases, then phases of
// random commands and ticks under different register settings, with random
// gaps on the sender and random stalls on the receiver. a scoreboard object
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_remote_velocity_slew_ramp_unit;
  import rvsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 7;
  localparam int ITEMS_PER_PHASE = 92;
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the ramp state and registers, expected results
  // --------------------------------------------------------------------------
  class ramp_scoreboard;
    cfg_t                    regs;
    logic [SEQ_W-1:0]        prev_cmd_seq;
    logic [SEQ_W-1:0]        prev_remote_seq;
    logic signed [VEL_W-1:0] tgt_fwd;
    logic signed [VEL_W-1:0] tgt_turn;
    logic signed [VEL_W-1:0] ramp_fwd;
    logic signed [VEL_W-1:0] ramp_turn;
    logic                    tgt_live;
    logic [TIME_W-1:0]       remote_stamp;
    logic [TIME_W-1:0]       ramp_stamp;
    res_t                    expected_q[$];
    int                      errors;

    function new();
      regs.fwd_accel  = FWD_ACCEL_RST;
      regs.turn_accel = TURN_ACCEL_RST;
      regs.stop_accel = STOP_ACCEL_RST;
      regs.timeout_ms = TIMEOUT_RST;
      regs.deadband   = DEADBAND_RST;
      regs.max_dt_ms  = MAX_DT_RST;
      prev_cmd_seq    = '0;
      prev_remote_seq = '0;
      tgt_fwd         = '0;
      tgt_turn        = '0;
      ramp_fwd        = '0;
      ramp_turn       = '0;
      tgt_live        = 1'b0;
      remote_stamp    = '0;
      ramp_stamp      = '0;
      errors          = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_FWD_ACCEL:  regs.fwd_accel  = data[ACC_W-1:0];
        CFG_TURN_ACCEL: regs.turn_accel = data[ACC_W-1:0];
        CFG_STOP_ACCEL: regs.stop_accel = data[ACC_W-1:0];
        CFG_TIMEOUT:    regs.timeout_ms = data[TMO_W-1:0];
        CFG_DEADBAND:   regs.deadband   = data[DB_W-1:0];
        CFG_MAX_DT:     regs.max_dt_ms  = data[DT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint magnitude(logic signed [VEL_W-1:0] v);
      longint w;
      w = longint'(v);
      return (w < 0) ? -w : w;
    endfunction

    function logic signed [VEL_W-1:0] slew_toward(logic signed [VEL_W-1:0] cur,
                                                   logic signed [VEL_W-1:0] tgt,
                                                   longint step);
      longint c;
      longint t;
      c = longint'(cur);
      t = longint'(tgt);
      if (t > c + step) c = c + step;
      else if (t < c - step) c = c - step;
      else c = t;
      return c[VEL_W-1:0];
    endfunction

    function void note_item(item_t it);
      res_t              want;
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] dt;
      longint            fstep;
      longint            tstep;
      logic              stale;
      want.cmd_taken = 1'b0;
      if (it.action == ACT_TICK) begin
        // watchdog on the remote command first, then the ramp
        age = it.now_ms - remote_stamp;
        if (tgt_live && age > TIME_W'(regs.timeout_ms)) begin
          tgt_fwd  = '0;
          tgt_turn = '0;
          tgt_live = 1'b0;
        end
        if (ramp_stamp == '0) ramp_stamp = it.now_ms;
        dt = it.now_ms - ramp_stamp;
        if (dt > TIME_W'(regs.max_dt_ms)) dt = TIME_W'(regs.max_dt_ms);
        ramp_stamp = it.now_ms;
        fstep = (magnitude(tgt_fwd) < longint'(regs.deadband)) ?
                longint'(regs.stop_accel) : longint'(regs.fwd_accel);
        tstep = (magnitude(tgt_turn) < longint'(regs.deadband)) ?
                longint'(regs.stop_accel) : longint'(regs.turn_accel);
        ramp_fwd  = slew_toward(ramp_fwd, tgt_fwd, fstep * longint'(dt));
        ramp_turn = slew_toward(ramp_turn, tgt_turn, tstep * longint'(dt));
      end else if (it.cmd_seq != '0 && it.cmd_seq != prev_cmd_seq) begin
        prev_cmd_seq   = it.cmd_seq;
        want.cmd_taken = 1'b1;
        stale          = 1'b0;
        if (it.preset) begin
          ramp_fwd  = it.fwd_value;
          ramp_turn = it.turn_value;
        end
        if (it.has_fwd || it.has_turn) begin
          if (it.remote_seq != '0 && it.remote_seq < prev_remote_seq) begin
            stale = 1'b1;
          end else begin
            if (it.remote_seq != '0) prev_remote_seq = it.remote_seq;
            if (it.has_fwd) tgt_fwd = it.fwd_value;
            if (it.has_turn) tgt_turn = it.turn_value;
            tgt_live = magnitude(tgt_fwd) > longint'(regs.deadband) ||
                       magnitude(tgt_turn) > longint'(regs.deadband);
            remote_stamp = it.now_ms;
          end
        end
        if (!stale && (it.stop || it.disable_req)) begin
          tgt_fwd   = '0;
          tgt_turn  = '0;
          tgt_live  = 1'b0;
          ramp_fwd  = '0;
          ramp_turn = '0;
        end
      end
      want.ramped_fwd    = ramp_fwd;
      want.ramped_turn   = ramp_turn;
      want.target_active = tgt_live;
      expected_q.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got fwd %0d turn %0d",
                 $time, got.ramped_fwd, got.ramped_turn);
        $display("%0t: unexpected result, expected none, got act %0b taken %0b",
                 $time, got.target_active, got.cmd_taken);
        return;
      end
      want = expected_q.pop_front();
      if (got.ramped_fwd !== want.ramped_fwd) begin
        errors++;
        $display("%0t: ramped_fwd expected %0d actual %0d", $time, want.ramped_fwd,
                 got.ramped_fwd);
      end
      if (got.ramped_turn !== want.ramped_turn) begin
        errors++;
        $display("%0t: ramped_turn expected %0d actual %0d", $time, want.ramped_turn,
                 got.ramped_turn);
      end
      if (got.target_active !== want.target_active) begin
        errors++;
        $display("%0t: target_active expected %0b actual %0b", $time, want.target_active,
                 got.target_active);
      end
      if (got.cmd_taken !== want.cmd_taken) begin
        errors++;
        $display("%0t: cmd_taken expected %0b actual %0b", $time, want.cmd_taken,
                 got.cmd_taken);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block ports
  // --------------------------------------------------------------------------
  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    action_i;
  logic [TIME_W-1:0]       now_ms_i;
  logic [SEQ_W-1:0]        cmd_seq_i;
  logic [SEQ_W-1:0]        remote_seq_i;
  logic                    preset_i;
  logic                    has_fwd_i;
  logic                    has_turn_i;
  logic signed [VEL_W-1:0] fwd_value_i;
  logic signed [VEL_W-1:0] turn_value_i;
  logic                    stop_i;
  logic                    disable_req_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VEL_W-1:0] ramped_fwd_o;
  logic signed [VEL_W-1:0] ramped_turn_o;
  logic                    target_active_o;
  logic                    cmd_taken_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DAT_W-1:0]    cfg_data_i;

  remote_velocity_slew_ramp_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .now_ms_i        (now_ms_i),
    .cmd_seq_i       (cmd_seq_i),
    .remote_seq_i    (remote_seq_i),
    .preset_i        (preset_i),
    .has_fwd_i       (has_fwd_i),
    .has_turn_i      (has_turn_i),
    .fwd_value_i     (fwd_value_i),
    .turn_value_i    (turn_value_i),
    .stop_i          (stop_i),
    .disable_req_i   (disable_req_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ramped_fwd_o    (ramped_fwd_o),
    .ramped_turn_o   (ramped_turn_o),
    .target_active_o (target_active_o),
    .cmd_taken_o     (cmd_taken_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  ramp_scoreboard    sb;
  bit                calm;         // when set, neither side idles
  logic [TIME_W-1:0] sim_ms;       // running millisecond clock of the stimulus
  int                idle_cycles;
  item_t             seen_item;
  res_t              seen_res;

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // monitor: every transfer is sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.apply_reg(cfg_index_i, cfg_data_i);
      // results first: a result never belongs to an item of the same edge
      if (out_valid_o && !out_stall_i) begin
        seen_res.ramped_fwd    = ramped_fwd_o;
        seen_res.ramped_turn   = ramped_turn_o;
        seen_res.target_active = target_active_o;
        seen_res.cmd_taken     = cmd_taken_o;
        sb.check_result(seen_res);
      end
      if (in_valid_i && !in_stall_o) begin
        seen_item.action      = action_e'(action_i);
        seen_item.now_ms      = now_ms_i;
        seen_item.cmd_seq     = cmd_seq_i;
        seen_item.remote_seq  = remote_seq_i;
        seen_item.preset      = preset_i;
        seen_item.has_fwd     = has_fwd_i;
        seen_item.has_turn    = has_turn_i;
        seen_item.fwd_value   = fwd_value_i;
        seen_item.turn_value  = turn_value_i;
        seen_item.stop        = stop_i;
        seen_item.disable_req = disable_req_i;
        sb.note_item(seen_item);
      end
      // watchdog: cycles with no transfer on any channel
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results still pending", $time,
                 sb.expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // velocities: mostly moderate, some around the deadband, some full range
  function automatic logic signed [VEL_W-1:0] pick_velocity();
    int          r;
    int unsigned db;
    db = 32'(sb.regs.deadband);
    r  = $urandom_range(0, 99);
    if (r < 45) return VEL_W'($urandom_range(0, 6000)) - VEL_W'(3000);
    if (r < 60) return VEL_W'($urandom_range(0, 2 * db + 2)) - VEL_W'(db + 1);
    if (r < 70) return '0;
    if (r < 85) return VEL_W'($urandom());
    case ($urandom_range(0, 3))
      0:       return VEL_MAX;
      1:       return VEL_MIN;
      2:       return '1;
      default: return VEL_W'(1);
    endcase
  endfunction

  function automatic item_t make_item(action_e act, logic [TIME_W-1:0] now,
                                      logic [SEQ_W-1:0] cseq, logic [SEQ_W-1:0] rseq,
                                      logic pre, logic hf, logic ht,
                                      logic signed [VEL_W-1:0] fv,
                                      logic signed [VEL_W-1:0] tv,
                                      logic stp, logic dis);
    item_t it;
    it.action      = act;
    it.now_ms      = now;
    it.cmd_seq     = cseq;
    it.remote_seq  = rseq;
    it.preset      = pre;
    it.has_fwd     = hf;
    it.has_turn    = ht;
    it.fwd_value   = fv;
    it.turn_value  = tv;
    it.stop        = stp;
    it.disable_req = dis;
    return it;
  endfunction

  // built at the falling edge, after every earlier item has been noted, so
  // the sequences follow what the block has actually taken
  function automatic item_t random_item();
    item_t            it;
    int               r;
    logic [SEQ_W-1:0] base;
    // junk everywhere first: ticks and noise commands keep it
    it.cmd_seq     = $urandom();
    it.remote_seq  = $urandom();
    it.preset      = 1'($urandom());
    it.has_fwd     = 1'($urandom());
    it.has_turn    = 1'($urandom());
    it.fwd_value   = VEL_W'($urandom());
    it.turn_value  = VEL_W'($urandom());
    it.stop        = 1'($urandom());
    it.disable_req = 1'($urandom());
    r = $urandom_range(0, 99);
    if (r < 70) sim_ms += $urandom_range(0, 12);
    else if (r < 88) sim_ms += $urandom_range(13, 90);
    else if (r < 97) sim_ms += $urandom_range(150, 700);
    else sim_ms = $urandom();
    it.now_ms = sim_ms;
    it.action = ($urandom_range(0, 99) < 50) ? ACT_TICK : ACT_CMD;
    if (it.action == ACT_CMD && $urandom_range(0, 9) != 0) begin
      base = sb.prev_cmd_seq;
      r    = $urandom_range(0, 99);
      if (r < 84) it.cmd_seq = base + 1'b1;
      else if (r < 91) it.cmd_seq = base;
      else if (r < 95) it.cmd_seq = '0;
      base = sb.prev_remote_seq;
      r    = $urandom_range(0, 99);
      if (r < 62) it.remote_seq = base + SEQ_W'($urandom_range(0, 3));
      else if (r < 72) it.remote_seq = '0;
      else if (r < 86) it.remote_seq = (base > 8) ? base - SEQ_W'($urandom_range(1, 8)) : '0;
      else if (r < 96) it.remote_seq = base + ($urandom() >> $urandom_range(4, 31));
      it.preset      = ($urandom_range(0, 9) == 0);
      it.has_fwd     = ($urandom_range(0, 9) < 7);
      it.has_turn    = ($urandom_range(0, 9) < 7);
      it.fwd_value   = pick_velocity();
      it.turn_value  = pick_velocity();
      it.stop        = ($urandom_range(0, 24) == 0);
      it.disable_req = ($urandom_range(0, 24) == 0);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // drivers: inputs change at the falling edge only
  // --------------------------------------------------------------------------
  task automatic await_slot();
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
  endtask

  // drive at the current falling edge, hold until the transfer
  task automatic put_item(input item_t it);
    in_valid_i    <= 1'b1;
    action_i      <= it.action;
    now_ms_i      <= it.now_ms;
    cmd_seq_i     <= it.cmd_seq;
    remote_seq_i  <= it.remote_seq;
    preset_i      <= it.preset;
    has_fwd_i     <= it.has_fwd;
    has_turn_i    <= it.has_turn;
    fwd_value_i   <= it.fwd_value;
    turn_value_i  <= it.turn_value;
    stop_i        <= it.stop;
    disable_req_i <= it.disable_req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_item(input item_t it);
    await_slot();
    put_item(it);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // all six registers, with random junk above the width of each register narrower than the data word
  task automatic program_regs(input int unsigned fa, input int unsigned ta,
                              input int unsigned sa, input int unsigned tmo,
                              input int unsigned db, input int unsigned mdt);
    logic [CFG_DAT_W-1:0] d;
    d = CFG_DAT_W'($urandom()); d[ACC_W-1:0] = ACC_W'(fa);  cfg_write(CFG_FWD_ACCEL, d);
    d = CFG_DAT_W'($urandom()); d[ACC_W-1:0] = ACC_W'(ta);  cfg_write(CFG_TURN_ACCEL, d);
    d = CFG_DAT_W'($urandom()); d[ACC_W-1:0] = ACC_W'(sa);  cfg_write(CFG_STOP_ACCEL, d);
    d = CFG_DAT_W'($urandom()); d[TMO_W-1:0] = TMO_W'(tmo); cfg_write(CFG_TIMEOUT, d);
    d = CFG_DAT_W'($urandom()); d[DB_W-1:0]  = DB_W'(db);   cfg_write(CFG_DEADBAND, d);
    d = CFG_DAT_W'($urandom()); d[DT_W-1:0]  = DT_W'(mdt);  cfg_write(CFG_MAX_DT, d);
  endtask

  // receiver: random stall before each result, or none in calm stretches
  task automatic run_receiver();
    int gap;
    forever begin
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  endtask

  // directed cases under the reset register values
  task automatic run_directed();
    // dropped: sequence zero
    send_item(make_item(ACT_CMD, 32'd90, '0, 32'd9, 1, 1, 1, 20'sd500, 20'sd500, 0, 0));
    // first tick starts the ramp with no elapsed time
    send_item(make_item(ACT_TICK, 32'd100, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    // extreme targets
    send_item(make_item(ACT_CMD, 32'd110, 32'd1, 32'd5, 0, 1, 1, VEL_MAX, VEL_MIN, 0, 0));
    send_item(make_item(ACT_TICK, 32'd120, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    // long gap: elapsed time clamps and the targets time out
    send_item(make_item(ACT_TICK, 32'd500, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    // dropped: repeated sequence
    send_item(make_item(ACT_CMD, 32'd501, 32'd1, 32'd6, 1, 1, 1, 20'sd77, 20'sd77, 0, 0));
    // preset alone loads the outputs
    send_item(make_item(ACT_CMD, 32'd502, 32'd2, '0, 1, 0, 0, 20'sd1000, -20'sd1000, 0, 0));
    // stale remote sequence: preset stays, target and stop are skipped
    send_item(make_item(ACT_CMD, 32'd503, 32'd3, 32'd3, 1, 1, 0, 20'sd7, 20'sd9, 1, 0));
    // target right at the deadband, remote sequence zero
    send_item(make_item(ACT_CMD, 32'd504, 32'd4, '0, 0, 1, 1, 20'sd1, 20'sd2, 0, 0));
    send_item(make_item(ACT_TICK, 32'd510, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    send_item(make_item(ACT_CMD, 32'd520, 32'd5, 32'd6, 0, 0, 1, '0, '0, 0, 0));
    send_item(make_item(ACT_TICK, 32'd530, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    // stop together with disable and a new target
    send_item(make_item(ACT_CMD, 32'd535, 32'd6, 32'd7, 0, 1, 0, 20'sd300, '0, 1, 1));
    send_item(make_item(ACT_CMD, 32'd540, 32'd7, 32'd7, 0, 1, 1, -20'sd300, 20'sd300, 0, 0));
    // disable alone
    send_item(make_item(ACT_CMD, 32'd545, 32'd8, '0, 0, 0, 0, '0, '0, 0, 1));
    // time wrap near the top of the millisecond counter
    send_item(make_item(ACT_CMD, 32'hFFFF_FFF0, 32'd9, 32'd8, 0, 1, 0, 20'sd5000, '0, 0, 0));
    send_item(make_item(ACT_TICK, 32'hFFFF_FFF8, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    send_item(make_item(ACT_TICK, 32'd4, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    // a tick at time zero restarts the ramp on the next tick
    send_item(make_item(ACT_TICK, 32'd0, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    send_item(make_item(ACT_TICK, 32'd20, '0, '0, 0, 0, 0, '0, '0, 0, 0));
    // all-ones sequences, preset to the most negative value
    send_item(make_item(ACT_CMD, 32'd25, '1, '1, 1, 1, 0, VEL_MIN, VEL_MIN, 0, 0));
    // tick with every command field set: all of it is ignored
    send_item(make_item(ACT_TICK, 32'd30, '1, '1, 1, 1, 1, VEL_MAX, VEL_MIN, 1, 1));
    send_item(make_item(ACT_TICK, 32'd45, '0, '0, 0, 0, 0, '0, '0, 0, 0));
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = 1'b0;
    now_ms_i      = '0;
    cmd_seq_i     = '0;
    remote_seq_i  = '0;
    preset_i      = 1'b0;
    has_fwd_i     = 1'b0;
    has_turn_i    = 1'b0;
    fwd_value_i   = '0;
    turn_value_i  = '0;
    stop_i        = 1'b0;
    disable_req_i = 1'b0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    calm          = 1'b0;
    sim_ms        = 32'd60;
    idle_cycles   = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fork
      run_receiver();
    join_none

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: run_directed();                               // reset values
        1: program_regs(0, 0, 0, 0, 0, 0);               // everything at the low end
        2: program_regs(1023, 1023, 1023, 65535, 255, 255);
        3: begin
          // back near the defaults, and the spare indexes must be ignored
          program_regs(20, 24, 30, 200, 1, 50);
          for (int i = int'(CFG_MAX_DT) + 1; i < (1 << CFG_IDX_W); i++) begin
            cfg_write(CFG_IDX_W'(i), CFG_DAT_W'($urandom()));
          end
        end
        default: program_regs($urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 400),
                              ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) :
                                                            $urandom_range(0, 255),
                              $urandom_range(0, 255));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // alternate stretches of random idling and back-to-back traffic
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        // hold off mid-phase until the pipeline is empty
        if (ph == 3 && n == 45) settle();
        await_slot();
        put_item(random_item());
      end
      settle();
    end

    repeat (6) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rvsr_pkg.sv
sv/rvsr_cfg_regs.sv
sv/rvsr_slew.sv
sv/rvsr_core.sv
sv/remote_velocity_slew_ramp_unit.sv
tb/sv/tb_remote_velocity_slew_ramp_unit.sv
